// ===== rtl/core/elevator_order_scheduler_assert.svh =====
// Assertion macros shared by the elevator order scheduler RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ELEVATOR_ORDER_SCHEDULER_ASSERT_SVH
`define ELEVATOR_ORDER_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EOS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("eos: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("eos: next-cycle check failed");

`endif

// ===== rtl/core/eos_pkg.sv =====
// Package of the elevator order scheduler: request and button codes,
// field widths and the command struct from controller to datapath.
// Depends on nothing.
package eos_pkg;

	localparam int REQ_W   = 3;
	localparam int KIND_W  = 2;
	localparam int FLOOR_W = 2;
	localparam int LAMP_W  = 12;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_NEW_ORDER = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SENSOR    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SERVE     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DEPART    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_EMERGENCY = 3'd4;

	// Button kinds.
	localparam logic [KIND_W-1:0] KIND_UP   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DOWN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CAB  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic apply;
		logic load;
	} eos_cmd_t;

endpackage

// ===== rtl/core/eos_req_if.sv =====
// Request channel of the elevator order scheduler: valid/ready and one event word.
// Depends on eos_pkg.
interface eos_req_if;
	logic                          valid;
	logic                          ready;
	logic [eos_pkg::REQ_W-1:0]     req_type;
	logic [eos_pkg::KIND_W-1:0]    button_kind;
	logic [eos_pkg::FLOOR_W-1:0]   floor_number;
	logic                          after_emergency;

	modport source (
		output valid, req_type, button_kind, floor_number, after_emergency,
		input  ready
	);
	modport sink (
		input  valid, req_type, button_kind, floor_number, after_emergency,
		output ready
	);
endinterface

// ===== rtl/core/eos_res_if.sv =====
// Result channel of the elevator order scheduler: valid/ready and one status word.
// Depends on eos_pkg.
interface eos_res_if;
	logic                          valid;
	logic                          ready;
	logic                          travel_up;
	logic [eos_pkg::FLOOR_W-1:0]   present_floor;
	logic                          floor_known;
	logic                          stop_here;
	logic                          order_here;
	logic                          any_order;
	logic [eos_pkg::LAMP_W-1:0]    order_lamps;
	logic                          order_elsewhere;
	logic                          from_cab;

	modport source (
		output valid, travel_up, present_floor, floor_known, stop_here, order_here,
		       any_order, order_lamps, order_elsewhere, from_cab,
		input  ready
	);
	modport sink (
		input  valid, travel_up, present_floor, floor_known, stop_here, order_here,
		       any_order, order_lamps, order_elsewhere, from_cab,
		output ready
	);
endinterface

// ===== rtl/core/eos_ctrl.sv =====
// Controller of the elevator order scheduler: capture, apply and report sequence.
// Depends on eos_pkg and elevator_order_scheduler_assert.svh.
`include "elevator_order_scheduler_assert.svh"

module eos_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output eos_pkg::eos_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_REPORT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	// A new word is taken only when no other word is in flight.
	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.apply   = (state_q == ST_EXEC);
	assign cmd.load    = (state_q == ST_REPORT) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (cmd.load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`EOS_ASSERT_NEXT(a_accept_to_exec, clk, arst_n, cmd.capture, state_q == ST_EXEC)
	`EOS_ASSERT_NEXT(a_exec_to_report, clk, arst_n, state_q == ST_EXEC, state_q == ST_REPORT)
	`EOS_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, cmd.load, out_valid_q && (state_q == ST_IDLE))

endmodule

// ===== rtl/core/eos_datapath.sv =====
// Datapath of the elevator order scheduler: event word register, order table,
// floor and direction state, and the registered result word.
// Depends on eos_pkg.
module eos_datapath #(
	parameter int FLOORS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  eos_pkg::eos_cmd_t           cmd,
	input  logic [eos_pkg::REQ_W-1:0]   req_type,
	input  logic [eos_pkg::KIND_W-1:0]  button_kind,
	input  logic [eos_pkg::FLOOR_W-1:0] floor_number,
	input  logic                        after_emergency,
	output logic                        travel_up,
	output logic [eos_pkg::FLOOR_W-1:0] present_floor,
	output logic                        floor_known,
	output logic                        stop_here,
	output logic                        order_here,
	output logic                        any_order,
	output logic [eos_pkg::LAMP_W-1:0]  order_lamps,
	output logic                        order_elsewhere,
	output logic                        from_cab
);

	localparam int TABLE_W = 3 * FLOORS;

	// Captured event word.
	logic [eos_pkg::REQ_W-1:0]   req_q;
	logic [eos_pkg::KIND_W-1:0]  kind_q;
	logic [eos_pkg::FLOOR_W-1:0] floor_in_q;
	logic                        after_em_q;

	// Order table, one vector per button kind, and car state.
	logic [FLOORS-1:0]           up_q, dn_q, cab_q;
	logic [FLOORS-1:0]           up_d, dn_d, cab_d;
	logic                        heading_q, heading_d;
	logic                        last_up_q, last_up_d;
	logic [eos_pkg::FLOOR_W-1:0] floor_reg_q, floor_reg_d;
	logic                        floor_valid_q, floor_valid_d;

	// Floor decodes and masks.
	logic [FLOORS-1:0] here_sel;
	logic [FLOORS-1:0] new_sel;
	logic [FLOORS-1:0] above_mask;
	logic [FLOORS-1:0] has_cur;
	logic [FLOORS-1:0] has_serve_up;
	logic [FLOORS-1:0] has_serve_dn;
	logic              above_cur, below_cur;
	logic              above_after_serve, below_after_serve;
	logic [TABLE_W-1:0]          table_bits;
	logic [eos_pkg::LAMP_W-1:0]  lamps;

	// Registered result word.
	logic                        travel_up_q;
	logic [eos_pkg::FLOOR_W-1:0] present_floor_q;
	logic                        floor_known_q;
	logic                        stop_here_q;
	logic                        order_here_q;
	logic                        any_order_q;
	logic [eos_pkg::LAMP_W-1:0]  order_lamps_q;
	logic                        order_elsewhere_q;
	logic                        from_cab_q;

	// Per-floor decode: the present floor, the ordered floor, and which floors
	// count as above the split set by the direction latched at the last floor.
	always_comb begin
		for (int f = 0; f < FLOORS; f++) begin
			here_sel[f]   = (int'(floor_reg_q) == f);
			new_sel[f]    = (int'(floor_in_q) == f);
			above_mask[f] = last_up_q ? (f > int'(floor_reg_q)) : (f >= int'(floor_reg_q));
		end
	end

	// Pending-order summaries on the current table and on the table as it
	// stands partway through servicing a floor.
	assign has_cur           = up_q | dn_q | cab_q;
	assign has_serve_up      = (up_q & ~here_sel) | dn_q | (cab_q & ~here_sel);
	assign has_serve_dn      = up_q | (dn_q & ~here_sel) | (cab_q & ~here_sel);
	assign above_cur         = |(has_cur & above_mask);
	assign below_cur         = |(has_cur & ~above_mask);
	assign above_after_serve = |(has_serve_up & above_mask);
	assign below_after_serve = |(has_serve_dn & ~above_mask);

	// Next state for the captured event.
	always_comb begin
		up_d          = up_q;
		dn_d          = dn_q;
		cab_d         = cab_q;
		heading_d     = heading_q;
		last_up_d     = last_up_q;
		floor_reg_d   = floor_reg_q;
		floor_valid_d = floor_valid_q;
		case (req_q)
			eos_pkg::REQ_NEW_ORDER: begin
				if (int'(floor_in_q) < FLOORS) begin
					case (kind_q)
						eos_pkg::KIND_UP:   up_d  = up_q | new_sel;
						eos_pkg::KIND_DOWN: dn_d  = dn_q | new_sel;
						eos_pkg::KIND_CAB:  cab_d = cab_q | new_sel;
						default: ;
					endcase
				end
			end
			eos_pkg::REQ_SENSOR: begin
				if (int'(floor_in_q) < FLOORS) begin
					floor_reg_d   = floor_in_q;
					floor_valid_d = 1'b1;
					last_up_d     = heading_q;
				end
			end
			eos_pkg::REQ_SERVE: begin
				if (floor_valid_q) begin
					cab_d = cab_q & ~here_sel;
					if (floor_reg_q == '0) begin
						up_d = up_q & ~here_sel;
					end else if (int'(floor_reg_q) == FLOORS - 1) begin
						dn_d = dn_q & ~here_sel;
					end else if (heading_q) begin
						up_d = up_q & ~here_sel;
						if (!above_after_serve) begin
							dn_d = dn_q & ~here_sel;
						end
					end else begin
						dn_d = dn_q & ~here_sel;
						if (!below_after_serve) begin
							up_d = up_q & ~here_sel;
						end
					end
				end
			end
			eos_pkg::REQ_DEPART: begin
				if (floor_valid_q) begin
					// Prefer the latched direction; keep heading when nothing waits.
					if (last_up_q) begin
						if (above_cur) begin
							heading_d = 1'b1;
						end else if (below_cur) begin
							heading_d = 1'b0;
						end
					end else begin
						if (below_cur) begin
							heading_d = 1'b0;
						end else if (above_cur) begin
							heading_d = 1'b1;
						end
					end
					if (!after_em_q) begin
						last_up_d = heading_d;
					end
				end
			end
			eos_pkg::REQ_EMERGENCY: begin
				up_d  = '0;
				dn_d  = '0;
				cab_d = '0;
			end
			default: ;
		endcase
	end

	// Event word register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q      <= req_type;
			kind_q     <= button_kind;
			floor_in_q <= floor_number;
			after_em_q <= after_emergency;
		end
	end

	// Table and car state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q          <= '0;
			dn_q          <= '0;
			cab_q         <= '0;
			heading_q     <= 1'b1;
			last_up_q     <= 1'b1;
			floor_reg_q   <= '0;
			floor_valid_q <= 1'b0;
		end else if (cmd.apply) begin
			up_q          <= up_d;
			dn_q          <= dn_d;
			cab_q         <= cab_d;
			heading_q     <= heading_d;
			last_up_q     <= last_up_d;
			floor_reg_q   <= floor_reg_d;
			floor_valid_q <= floor_valid_d;
		end
	end

	// Lamp word: table bit kind*FLOORS+floor, cut or padded to the lamp width.
	assign table_bits = {cab_q, dn_q, up_q};
	generate
		if (TABLE_W >= eos_pkg::LAMP_W) begin : g_lamps_cut
			assign lamps = table_bits[eos_pkg::LAMP_W-1:0];
		end else begin : g_lamps_pad
			assign lamps = {{(eos_pkg::LAMP_W - TABLE_W){1'b0}}, table_bits};
		end
	endgenerate

	// Result word, built from the state after the event.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			travel_up_q     <= heading_q;
			present_floor_q <= floor_reg_q;
			floor_known_q   <= floor_valid_q;
			order_here_q    <= floor_valid_q && |(has_cur & here_sel);
			any_order_q     <= |has_cur;
			order_lamps_q   <= lamps;
			stop_here_q     <= floor_valid_q && (|(cab_q & here_sel) ||
				(heading_q ? (|(up_q & here_sel) || !above_cur)
				           : (|(dn_q & here_sel) || !below_cur)));
			order_elsewhere_q <= (req_q == eos_pkg::REQ_NEW_ORDER) &&
				(!floor_valid_q || (floor_in_q != floor_reg_q));
			from_cab_q <= (req_q == eos_pkg::REQ_NEW_ORDER) && (kind_q == eos_pkg::KIND_CAB);
		end
	end

	assign travel_up       = travel_up_q;
	assign present_floor   = present_floor_q;
	assign floor_known     = floor_known_q;
	assign stop_here       = stop_here_q;
	assign order_here      = order_here_q;
	assign any_order       = any_order_q;
	assign order_lamps     = order_lamps_q;
	assign order_elsewhere = order_elsewhere_q;
	assign from_cab        = from_cab_q;

endmodule

// ===== rtl/core/elevator_order_scheduler.sv =====
// Elevator order scheduler: one result word for each event word.
// The event word is registered on acceptance and applied in the execute state; the
// result word is registered in the report step, which waits while an earlier result
// is not yet taken. A new event is taken only when the controller is idle again.
// Reset (arst_n low): order table empty, heading up, floor unknown, no result pending.
// Depends on eos_pkg, eos_req_if, eos_res_if, eos_ctrl and eos_datapath.
module elevator_order_scheduler #(
	parameter int FLOORS = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	eos_req_if.sink   request,
	eos_res_if.source result
);

	eos_pkg::eos_cmd_t cmd;

	// Sequencing of capture, update and report.
	eos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// Order table, car state and result register.
	eos_datapath #(
		.FLOORS (FLOORS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.req_type        (request.req_type),
		.button_kind     (request.button_kind),
		.floor_number    (request.floor_number),
		.after_emergency (request.after_emergency),
		.travel_up       (result.travel_up),
		.present_floor   (result.present_floor),
		.floor_known     (result.floor_known),
		.stop_here       (result.stop_here),
		.order_here      (result.order_here),
		.any_order       (result.any_order),
		.order_lamps     (result.order_lamps),
		.order_elsewhere (result.order_elsewhere),
		.from_cab        (result.from_cab)
	);

endmodule
